@@ rtl/sws_pkg.sv @@
`default_nettype none

package sws_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SEQ_SPACE    = 256;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;

    localparam int TIME_W = 32;
    localparam int TMO_W  = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(300);

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_NACK = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  seq_num;
        logic [31:0] now_ms;
        logic        source_ended;
    } t_in_item;

    typedef struct packed {
        logic        transmit;
        logic        is_resend;
        logic [5:0]  slot;
        logic [7:0]  sent_seq;
        logic        window_full;
        logic [6:0]  free_slots;
        logic        transfer_done;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [TIME_W-1:0] data;
    } t_time_wr;

endpackage

`default_nettype wire

@@ rtl/sws_time_mem.sv @@
`default_nettype none

module sws_time_mem
    import sws_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    input  wire t_time_wr          i_wr,
    output logic      [TIME_W-1:0] o_rd_data
);

    logic [TIME_W-1:0] r_mem [WINDOW_DEPTH];
    logic [TIME_W-1:0] r_rd_data;
    logic [SLOT_W-1:0] r_rd_addr;

    // write landing on the same edge as the read; held until the next read
    logic              r_fwd_vld;
    logic [SLOT_W-1:0] r_fwd_addr;
    logic [TIME_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_vld <= i_wr.en;
        end
        if (i_rd_en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = (r_fwd_vld && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

@@ rtl/sws_step.sv @@
`default_nettype none

module sws_step
    import sws_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_in_item          i_item,
    input  wire logic [TIME_W-1:0] i_sent_time,
    input  wire logic [TMO_W-1:0]  i_timeout,
    output t_out_item              o_result,
    output t_time_wr               o_time_wr
);

    logic [SEQ_W-1:0]        r_wstart, n_wstart;
    logic [SEQ_W-1:0]        r_next, n_next;
    logic [CNT_W-1:0]        r_free, n_free;
    logic [SEQ_W-1:0]        r_last, n_last;
    logic                    r_any, n_any;
    logic                    r_srcdone, n_srcdone;
    logic                    r_armed, n_armed;
    logic [WINDOW_DEPTH-1:0] r_resent, n_resent;

    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  seq_off;
    logic [CNT_W-1:0]  outst;
    logic              in_win;
    logic [SLOT_W-1:0] seq_slot;
    logic [SLOT_W-1:0] next_slot;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;

    assign seq       = SEQ_W'(i_item.seq_num);
    assign seq_off   = seq - r_wstart;
    assign outst     = CNT_W'(WINDOW_DEPTH) - r_free;
    assign in_win    = CMP_W'(seq_off) < CMP_W'(outst);
    assign seq_slot  = seq[SLOT_W-1:0];
    assign next_slot = r_next[SLOT_W-1:0];
    assign elapsed   = i_item.now_ms - i_sent_time;
    assign timed_out = elapsed > TIME_W'(i_timeout);

    always_comb begin
        n_wstart  = r_wstart;
        n_next    = r_next;
        n_free    = r_free;
        n_last    = r_last;
        n_any     = r_any;
        n_srcdone = r_srcdone;
        n_armed   = r_armed;
        n_resent  = r_resent;
        o_result  = '0;
        o_time_wr = '0;

        unique case (i_item.action)
            ACT_SEND: begin
                if (r_srcdone) begin
                    // final packet already out: drop
                end else if (r_free == '0) begin
                    o_result.window_full = 1'b1;
                end else begin
                    n_resent[next_slot] = 1'b0;
                    o_time_wr.en        = 1'b1;
                    o_time_wr.addr      = next_slot;
                    o_time_wr.data      = i_item.now_ms;
                    n_last              = r_next;
                    n_any               = 1'b1;
                    o_result.transmit   = 1'b1;
                    o_result.slot       = 6'(next_slot);
                    o_result.sent_seq   = 8'(r_next);
                    n_next              = r_next + SEQ_W'(1);
                    n_free              = r_free - CNT_W'(1);
                    if (i_item.source_ended) begin
                        n_srcdone = 1'b1;
                    end
                end
            end
            ACT_ACK: begin
                if (in_win) begin
                    n_free   = r_free + CNT_W'(seq_off) + CNT_W'(1);
                    n_wstart = seq + SEQ_W'(1);
                    n_armed  = 1'b1;
                end else begin
                    // an ack outside the window arms only as a duplicate of the sequence just below it
                    n_armed = (seq == (r_wstart - SEQ_W'(1)));
                end
                o_result.transfer_done = r_any && r_srcdone && (seq == r_last)
                                         && (n_free == CNT_W'(WINDOW_DEPTH));
            end
            ACT_NACK: begin
                if (r_armed && in_win && (!r_resent[seq_slot] || timed_out)) begin
                    n_resent[seq_slot] = 1'b1;
                    o_time_wr.en       = 1'b1;
                    o_time_wr.addr     = seq_slot;
                    o_time_wr.data     = i_item.now_ms;
                    o_result.transmit  = 1'b1;
                    o_result.is_resend = 1'b1;
                    o_result.slot      = 6'(seq_slot);
                    o_result.sent_seq  = 8'(seq);
                end
            end
            default: begin
            end
        endcase

        o_result.free_slots = 7'(n_free);
        if (!i_fire) begin
            o_time_wr.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart  <= '0;
            r_next    <= '0;
            r_free    <= CNT_W'(WINDOW_DEPTH);
            r_last    <= '0;
            r_any     <= 1'b0;
            r_srcdone <= 1'b0;
            r_armed   <= 1'b0;
            r_resent  <= '0;
        end else if (i_fire) begin
            r_wstart  <= n_wstart;
            r_next    <= n_next;
            r_free    <= n_free;
            r_last    <= n_last;
            r_any     <= n_any;
            r_srcdone <= n_srcdone;
            r_armed   <= n_armed;
            r_resent  <= n_resent;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sliding_window_sender_core.sv @@
// Sliding window sender core: window bookkeeping for a cumulative-ack + NACK ARQ sender.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one request per item, either a
// send of a new packet, a cumulative ack or a NACK of one sequence. A request is taken
// on a rising edge with i_in_valid high and o_in_stall low.
// Output channel (o_out_valid / i_out_stall / o_out_item): exactly one result per
// request, in request order: transmit flag, slot, sequence, window-full, free slots,
// transfer done.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): retransmit timeout in ms.
// Always ready; write it only while no request is in flight.
//
// A request passes through the input register (with the send-time memory read), then
// one compute pass into the result register. Throughput: one request per cycle while
// the receiver does not stall; the send-time memory has one read and one write port
// and a bypass for the write issued on the same edge as the next read.
// When the receiver stalls, the result register holds, the input register fills and
// o_in_stall stays high while that request cannot move on; nothing is dropped.
// Reset (i_rst_n low, synchronous) empties both registers, opens the full window at
// sequence 0 and sets the timeout to 300 ms. No clearing pass is needed.
`default_nettype none

module sliding_window_sender_core
    import sws_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    // timeout register write
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [TMO_W-1:0] i_cfg_data
);

    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic             r_o_valid;
    t_out_item        r_o_item;
    logic [TMO_W-1:0] r_timeout;

    logic              accept;
    logic              fire;
    logic [TIME_W-1:0] sent_time;
    t_out_item         result;
    t_time_wr          time_wr;

    // stage 1 drains into the result register when that is empty or being taken
    assign fire       = r_s1_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_timeout  <= TIMEOUT_RESET;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
        if (fire) begin
            r_o_item <= result;
        end
    end

    // per-slot send times, read with the request so the NACK check has it in stage 1
    sws_time_mem u_time_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_in_item.seq_num[SLOT_W-1:0]),
        .i_wr      (time_wr),
        .o_rd_data (sent_time)
    );

    sws_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_s1_item),
        .i_sent_time (sent_time),
        .i_timeout   (r_timeout),
        .o_result    (result),
        .o_time_wr   (time_wr)
    );

endmodule

`default_nettype wire
